FILE: sv/mrbd_pkg.sv
// Shared types, constants and helper functions of the meter response BCD decoder.
// Used by every module of the block and by its checker. No dependencies.

package mrbd_pkg;

	localparam logic [4:0] VALUES_FRAME_LEN = 5'd14;
	localparam logic [4:0] ENERGY_FRAME_LEN = 5'd23;
	localparam logic [4:0] FIRST_PAYLOAD = 5'd5;
	localparam int STORE_DEPTH = 16;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_CRC_ERR = 1'b1;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic frame_start;
	} in_item_t;

	typedef struct packed {
		logic status;
		logic [14:0] voltage_value;
		logic [14:0] current_value;
		logic [20:0] power_value;
		logic [27:0] energy_tariff_one;
		logic [27:0] energy_tariff_two;
		logic [27:0] energy_tariff_three;
		logic [27:0] energy_tariff_four;
	} out_item_t;

	typedef logic [STORE_DEPTH-1:0][7:0] store_t;

	typedef struct packed {
		logic last;
		logic crc_ok;
	} frm_status_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] pair_value(input logic [7:0] b);
		return 8'(b[7:4] * 4'd10) + {4'h0, b[3:0]};
	endfunction

endpackage

FILE: sv/mrbd_frame.sv
// Frame tracker: byte position, running CRC-16, received CRC low byte and payload store.
// Depends on mrbd_pkg.

module mrbd_frame (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic mode,
	input mrbd_pkg::in_item_t item,
	output mrbd_pkg::frm_status_t stat,
	output mrbd_pkg::store_t store
);

	logic [4:0] pos_q;
	logic [15:0] crc_q;
	logic [7:0] crc_low_q;
	mrbd_pkg::store_t store_q;

	logic [4:0] pos_eff;
	logic [15:0] crc_eff;
	logic [4:0] len_m2;
	logic in_payload;
	logic [3:0] store_idx;

	assign pos_eff = item.frame_start ? 5'd0 : pos_q;
	assign crc_eff = item.frame_start ? mrbd_pkg::CRC_INIT : crc_q;
	assign len_m2 = (mode ? mrbd_pkg::ENERGY_FRAME_LEN : mrbd_pkg::VALUES_FRAME_LEN) - 5'd2;
	assign in_payload = (pos_eff >= mrbd_pkg::FIRST_PAYLOAD) &&
		(pos_eff < mrbd_pkg::FIRST_PAYLOAD + 5'(mrbd_pkg::STORE_DEPTH));
	assign store_idx = 4'(pos_eff - mrbd_pkg::FIRST_PAYLOAD);

	assign stat.last = pos_eff > len_m2;
	assign stat.crc_ok = (crc_low_q == crc_eff[7:0]) && (item.rx_byte == crc_eff[15:8]);
	assign store = store_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 5'd0;
			crc_q <= mrbd_pkg::CRC_INIT;
			crc_low_q <= 8'h00;
		end else if (step) begin
			if (pos_eff > len_m2) begin
				pos_q <= 5'd0;
				crc_q <= mrbd_pkg::CRC_INIT;
			end else if (pos_eff == len_m2) begin
				crc_low_q <= item.rx_byte;
				pos_q <= pos_eff + 5'd1;
				crc_q <= crc_eff;
			end else begin
				crc_q <= mrbd_pkg::crc_byte(crc_eff, item.rx_byte);
				pos_q <= pos_eff + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && !(pos_eff >= len_m2) && in_payload) begin
			store_q[store_idx] <= item.rx_byte;
		end
	end

endmodule

FILE: sv/mrbd_decode.sv
// BCD decoder: turns the stored payload bytes into the result fields for either mode.
// Depends on mrbd_pkg.

module mrbd_decode (
	input logic mode,
	input logic crc_ok,
	input mrbd_pkg::store_t store,
	output mrbd_pkg::out_item_t result
);

	logic [7:0] pv [mrbd_pkg::STORE_DEPTH];
	logic [27:0] tariff [4];

	always_comb begin
		for (int i = 0; i < mrbd_pkg::STORE_DEPTH; i++) begin
			pv[i] = mrbd_pkg::pair_value(store[i]);
		end
		for (int t = 0; t < 4; t++) begin
			tariff[t] = 28'(pv[4*t] * 28'd1000000) + 28'(pv[4*t+1] * 28'd10000)
				+ 28'(pv[4*t+2] * 28'd100) + 28'(pv[4*t+3]);
		end
	end

	always_comb begin
		result = '0;
		if (!crc_ok) begin
			result.status = mrbd_pkg::STATUS_CRC_ERR;
		end else if (!mode) begin
			result.status = mrbd_pkg::STATUS_OK;
			result.voltage_value = 15'(pv[0] * 15'd100) + 15'(pv[1]);
			result.current_value = 15'(pv[2] * 15'd100) + 15'(pv[3]);
			result.power_value = 21'(pv[4] * 21'd10000) + 21'(pv[5] * 21'd100) + 21'(pv[6]);
		end else begin
			result.status = mrbd_pkg::STATUS_OK;
			result.energy_tariff_one = tariff[0];
			result.energy_tariff_two = tariff[1];
			result.energy_tariff_three = tariff[2];
			result.energy_tariff_four = tariff[3];
		end
	end

endmodule

FILE: sv/meter_response_bcd_decoder_core.sv
// Top level: input register, frame tracker, BCD decoder and result register.
// A frame's result is registered as its last byte leaves the input register.
// Throughput: one byte per cycle; the input stalls only while a result waits
// in the full result register and the byte in the input register is a last byte.
// Reset clears position, CRC (to 0xFFFF), received CRC byte, mode and both valid flags.
// Depends on mrbd_pkg, mrbd_frame and mrbd_decode.

module meter_response_bcd_decoder_core (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	output logic byte_ready,
	input mrbd_pkg::in_item_t byte_item,
	output logic result_valid,
	input logic result_ready,
	output mrbd_pkg::out_item_t result_item,
	input logic wr_en,
	input logic wr_data
);

	logic mode_q;
	logic valid_s1;
	mrbd_pkg::in_item_t item_s1;
	logic go;
	mrbd_pkg::frm_status_t stat;
	mrbd_pkg::store_t store;
	mrbd_pkg::out_item_t decoded;

	assign go = valid_s1 && (!stat.last || !result_valid || result_ready);
	assign byte_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			valid_s1 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (wr_en) begin
				mode_q <= wr_data;
			end
			if (byte_ready) begin
				valid_s1 <= byte_valid;
			end
			if (go && stat.last) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
		if (go && stat.last) begin
			result_item <= decoded;
		end
	end

	mrbd_frame u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.step(go),
		.mode(mode_q),
		.item(item_s1),
		.stat(stat),
		.store(store)
	);

	mrbd_decode u_decode (
		.mode(mode_q),
		.crc_ok(stat.crc_ok),
		.store(store),
		.result(decoded)
	);

endmodule

FILE: sv/mrbd_checker.sv
// Port-level checker for the meter response BCD decoder, bound to the top level.
// Depends on mrbd_pkg and meter_response_bcd_decoder_core.

module mrbd_port_assertions (
	input logic clk,
	input logic arst_n,
	input logic byte_ready,
	input logic result_valid,
	input logic result_ready,
	input mrbd_pkg::out_item_t result_item
);

	logic values_nonzero;
	logic energy_nonzero;

	assign values_nonzero = (result_item.voltage_value != '0) ||
		(result_item.current_value != '0) || (result_item.power_value != '0);
	assign energy_nonzero = (result_item.energy_tariff_one != '0) ||
		(result_item.energy_tariff_two != '0) || (result_item.energy_tariff_three != '0) ||
		(result_item.energy_tariff_four != '0);

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_item))
		else $error("Result item changed or dropped while stalled.");

	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.status == mrbd_pkg::STATUS_CRC_ERR
		|-> !values_nonzero && !energy_nonzero)
		else $error("Mismatch result carries nonzero values.");

	a_one_mode: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && values_nonzero |-> !energy_nonzero)
		else $error("Result mixes values and energy fields.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> result_valid)
		else $error("Input stalled while the result register is empty.");

endmodule

bind meter_response_bcd_decoder_core mrbd_port_assertions u_mrbd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.byte_ready(byte_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result_item(result_item)
);

FILE: sim/mrbd_checker.sv
// Checker for the meter response BCD decoder: watches the byte, result and mode ports,
// predicts each frame's result and compares it field by field.
// Depends on mrbd_pkg for the item types and frame constants.
`timescale 1ns / 100ps

module mrbd_checker (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	input logic byte_ready,
	input mrbd_pkg::in_item_t byte_item,
	input logic result_valid,
	input logic result_ready,
	input mrbd_pkg::out_item_t result_item,
	input logic wr_en,
	input logic wr_data,
	output int fails,
	output int pending,
	output int bytes_taken,
	output int results_seen,
	output int crc_err_seen
);

	logic frame_mode;
	logic [4:0] byte_pos;
	logic [15:0] crc_acc;
	logic [7:0] crc_low_seen;
	logic [7:0] payload_bytes [mrbd_pkg::STORE_DEPTH];
	mrbd_pkg::out_item_t expected_readings [$];

	initial fails = 0;

	function automatic logic [15:0] crc16_modbus_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ mrbd_pkg::CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	function automatic int digit_pair(input int p);
		logic [7:0] b;
		b = payload_bytes[p - int'(mrbd_pkg::FIRST_PAYLOAD)];
		return int'(b[7:4]) * 10 + int'(b[3:0]);
	endfunction

	function automatic int tariff_total(input int p);
		return digit_pair(p) * 1000000 + digit_pair(p + 1) * 10000
			+ digit_pair(p + 2) * 100 + digit_pair(p + 3);
	endfunction

	task automatic take_meter_byte(input mrbd_pkg::in_item_t it);
		int len;
		mrbd_pkg::out_item_t r;
		len = frame_mode ? int'(mrbd_pkg::ENERGY_FRAME_LEN) : int'(mrbd_pkg::VALUES_FRAME_LEN);
		if (it.frame_start) begin
			byte_pos = '0;
			crc_acc = mrbd_pkg::CRC_INIT;
		end
		if (byte_pos < len - 2) begin
			crc_acc = crc16_modbus_step(crc_acc, it.rx_byte);
			if (byte_pos >= mrbd_pkg::FIRST_PAYLOAD &&
					byte_pos < mrbd_pkg::FIRST_PAYLOAD + mrbd_pkg::STORE_DEPTH) begin
				payload_bytes[byte_pos - mrbd_pkg::FIRST_PAYLOAD] = it.rx_byte;
			end
			byte_pos++;
		end else if (byte_pos == len - 2) begin
			crc_low_seen = it.rx_byte;
			byte_pos++;
		end else begin
			r = '0;
			if (crc_low_seen != crc_acc[7:0] || it.rx_byte != crc_acc[15:8]) begin
				r.status = mrbd_pkg::STATUS_CRC_ERR;
			end else if (!frame_mode) begin
				r.status = mrbd_pkg::STATUS_OK;
				r.voltage_value = 15'(digit_pair(5) * 100 + digit_pair(6));
				r.current_value = 15'(digit_pair(7) * 100 + digit_pair(8));
				r.power_value = 21'(digit_pair(9) * 10000 + digit_pair(10) * 100
					+ digit_pair(11));
			end else begin
				r.status = mrbd_pkg::STATUS_OK;
				r.energy_tariff_one = 28'(tariff_total(5));
				r.energy_tariff_two = 28'(tariff_total(9));
				r.energy_tariff_three = 28'(tariff_total(13));
				r.energy_tariff_four = 28'(tariff_total(17));
			end
			expected_readings.push_back(r);
			byte_pos = '0;
			crc_acc = mrbd_pkg::CRC_INIT;
		end
	endtask

	task automatic report(input string what);
		if (fails < 50) begin
			$display("mismatch at %0t: %s", $realtime, what);
		end
		fails++;
	endtask

	task automatic field_check(input string name, input longint want, input longint got);
		if (want != got) begin
			report($sformatf("%s expected %0d, got %0d", name, want, got));
		end
	endtask

	task automatic check_reading(input mrbd_pkg::out_item_t got);
		mrbd_pkg::out_item_t want;
		if (expected_readings.size() == 0) begin
			report($sformatf("result with no frame completed, status %0d", got.status));
		end else begin
			want = expected_readings.pop_front();
			field_check("status", want.status, got.status);
			field_check("voltage", want.voltage_value, got.voltage_value);
			field_check("current", want.current_value, got.current_value);
			field_check("power", want.power_value, got.power_value);
			field_check("tariff 1", want.energy_tariff_one, got.energy_tariff_one);
			field_check("tariff 2", want.energy_tariff_two, got.energy_tariff_two);
			field_check("tariff 3", want.energy_tariff_three, got.energy_tariff_three);
			field_check("tariff 4", want.energy_tariff_four, got.energy_tariff_four);
			if (want.status == mrbd_pkg::STATUS_CRC_ERR) begin
				crc_err_seen <= crc_err_seen + 1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode = 1'b0;
			byte_pos = '0;
			crc_acc = mrbd_pkg::CRC_INIT;
			crc_low_seen = '0;
			expected_readings.delete();
			pending <= 0;
			bytes_taken <= 0;
			results_seen <= 0;
			crc_err_seen <= 0;
		end else begin
			if (byte_valid && byte_ready) begin
				take_meter_byte(byte_item);
				bytes_taken <= bytes_taken + 1;
			end
			if (result_valid && result_ready) begin
				check_reading(result_item);
				results_seen <= results_seen + 1;
			end
			if (wr_en) begin
				frame_mode = wr_data;
			end
			pending <= expected_readings.size();
		end
	end

endmodule

FILE: sim/testbench.sv
// Top of the meter response decoder testbench: clock, reset, byte and mode stimulus,
// result back-pressure, watchdog and verdict.
// Depends on mrbd_pkg, meter_response_bcd_decoder_core and mrbd_checker.
`timescale 1ns / 100ps

module testbench;

	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_ready;
	mrbd_pkg::in_item_t byte_item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	mrbd_pkg::out_item_t result_item;
	logic wr_en = 1'b0;
	logic wr_data = 1'b0;

	int fails;
	int pending;
	int bytes_taken;
	int results_seen;
	int crc_err_seen;
	int quiet_cycles = 0;
	int mode_writes = 0;
	int phase = 0;

	bit tx_gaps = 1'b1;
	bit rx_stalls = 1'b1;
	bit long_hold_req = 1'b0;
	bit cur_mode = 1'b0;
	bit aligned = 1'b1;
	logic [7:0] frame_buf [0:22];

	meter_response_bcd_decoder_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item(byte_item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_item(result_item),
		.wr_en(wr_en),
		.wr_data(wr_data)
	);

	mrbd_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item(byte_item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_item(result_item),
		.wr_en(wr_en),
		.wr_data(wr_data),
		.fails(fails),
		.pending(pending),
		.bytes_taken(bytes_taken),
		.results_seen(results_seen),
		.crc_err_seen(crc_err_seen)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && byte_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	always begin
		@(posedge clk);
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			result_ready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			result_ready <= 1'b1;
		end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
			result_ready <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			result_ready <= 1'b1;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// The byte at position skip is left out of the CRC; bad selects which CRC byte is corrupted.
	function automatic void build_frame(input int len, input int skip, input int fill,
			input bit bcd, input int bad);
		logic [15:0] c;
		logic [7:0] b;
		c = mrbd_pkg::CRC_INIT;
		for (int i = 0; i < len - 2; i++) begin
			if (i >= 5 && fill >= 0) begin
				b = 8'(fill);
			end else if (bcd) begin
				b = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
			end else begin
				b = 8'($urandom);
			end
			frame_buf[i] = b;
			if (i != skip) begin
				c = mrbd_pkg::crc_byte(c, b);
			end
		end
		frame_buf[len - 2] = c[7:0];
		frame_buf[len - 1] = c[15:8];
		if (bad == 1 || bad == 2) begin
			frame_buf[len - 3 + bad] ^= 8'(1 << $urandom_range(0, 7));
		end else if (bad == 3) begin
			frame_buf[len - 2 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic st);
		byte_item <= '{rx_byte: b, frame_start: st};
		byte_valid <= 1'b1;
		do @(posedge clk); while (!byte_ready);
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic send_span(input int from, input int upto, input bit st);
		for (int i = from; i < upto; i++) begin
			send_byte(frame_buf[i], st && i == from);
		end
	endtask

	task automatic wait_drained();
		byte_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_mode(input bit m);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		wr_en <= 1'b1;
		wr_data <= m;
		@(posedge clk);
		wr_en <= 1'b0;
		cur_mode = m;
		mode_writes++;
	endtask

	task automatic send_random_frame();
		int len;
		int kind;
		int cut;
		bit st;
		len = cur_mode ? int'(mrbd_pkg::ENERGY_FRAME_LEN) : int'(mrbd_pkg::VALUES_FRAME_LEN);
		kind = $urandom_range(0, 9);
		st = aligned ? bit'($urandom_range(0, 1)) : 1'b1;
		if (kind == 8) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom));
			aligned = 1'b0;
		end else begin
			build_frame(len, -1, -1, kind != 9, (kind == 6) ? 3 : 0);
			cut = (kind == 7) ? $urandom_range(1, len - 1) : len;
			send_span(0, cut, st);
			aligned = (cut == len);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first frame is a whole energy frame, so every payload entry is written.
		write_mode(1'b1);
		build_frame(23, -1, 8'hFF, 1'b0, 0);
		send_span(0, 23, 1'b1);
		build_frame(23, -1, 8'h99, 1'b0, 0);
		send_span(0, 23, 1'b0);
		write_mode(1'b0);
		build_frame(14, -1, 8'h00, 1'b0, 0);
		send_span(0, 14, 1'b1);
		build_frame(14, -1, 8'h99, 1'b0, 1);
		send_span(0, 14, 1'b0);
		build_frame(14, -1, -1, 1'b1, 2);
		send_span(0, 14, 1'b1);
		build_frame(14, -1, -1, 1'b1, 0);
		send_span(0, 7, 1'b1);
		build_frame(14, -1, -1, 1'b1, 0);
		send_span(0, 14, 1'b1);

		// A values frame switched to energy after its CRC low byte position.
		build_frame(23, 12, -1, 1'b1, 0);
		send_span(0, 13, 1'b1);
		write_mode(1'b1);
		send_span(13, 23, 1'b0);

		// An energy frame switched to values past the values frame's last byte.
		build_frame(23, -1, -1, 1'b1, 0);
		send_span(0, 20, 1'b1);
		write_mode(1'b0);
		send_span(20, 21, 1'b0);

		while (bytes_taken < 480) begin
			write_mode(phase % 4 == 1 || phase % 4 == 2);
			tx_gaps = $urandom_range(0, 2) != 0;
			rx_stalls = $urandom_range(0, 2) != 0;
			if (phase == 1) begin
				tx_gaps = 1'b0;
				long_hold_req = 1'b1;
			end
			for (int k = 0; k < 6; k++) begin
				send_random_frame();
				if (phase == 2 && k == 2) begin
					wait_drained();
				end
			end
			phase++;
		end

		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		write_mode(1'b1);
		repeat (3) send_random_frame();
		write_mode(1'b0);
		repeat (3) send_random_frame();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d bytes in both frame modes over %0d mode writes; checked %0d results,",
			bytes_taken, mode_writes, results_seen);
		$display("%0d of them CRC errors, with idle gaps, a long result hold-off%s",
			crc_err_seen, " and mid-frame mode changes.");
		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
